// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define NWT_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nwt check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define NWT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nwt check failed");

`endif

// ===== rtl/core/nwt_pkg.sv =====
`default_nettype none

package nwt_pkg;

  // Magnitude width after the range check (below one billion)
  localparam int unsigned MAG_W   = 30;
  localparam int unsigned DIGITS  = 9;
  localparam int unsigned BCD_W   = 4 * DIGITS;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned WORD_W  = 7;

  localparam logic [31:0] BILLION = 32'd1_000_000_000;

  // Special token codes
  localparam logic [WORD_W-1:0] W_ZERO  = 7'd0;
  localparam logic [WORD_W-1:0] W_ONE_N = 7'd100;
  localparam logic [WORD_W-1:0] W_HUND  = 7'd101;
  localparam logic [WORD_W-1:0] W_THOUS = 7'd102;
  localparam logic [WORD_W-1:0] W_MILL  = 7'd103;
  localparam logic [WORD_W-1:0] W_AND   = 7'd104;
  localparam logic [WORD_W-1:0] W_MINUS = 7'd105;

  // Micro-operations
  typedef enum logic [3:0] {
    OP_MINUS,   // minus sign if negative
    OP_ZERO,    // token zero if input is zero
    OP_BIG,     // error token if out of range
    OP_JDONE,   // jump when nothing more to speak
    OP_CONV,    // hold here while binary-to-decimal runs
    OP_JZ,      // jump past a group that is zero
    OP_HDIG,    // hundreds digit
    OP_HUND,    // word hundred
    OP_ANDH,    // and after hundred
    OP_TENS,    // teen or tens word
    OP_UNIT,    // unit after a tens word
    OP_SUFX,    // million / thousand
    OP_ANDS,    // and after a group suffix
    OP_END      // flush last token, go idle
  } op_e;

  typedef enum logic [1:0] {
    GRP_MILL,
    GRP_THOUS,
    GRP_UNIT
  } grp_e;

  typedef struct packed {
    op_e               op;
    grp_e              grp;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  localparam logic [STEP_W-1:0] S_END = 5'd27;

  // Microprogram ROM
  function automatic ctrl_t nwt_ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '{op: OP_END, grp: GRP_UNIT, target: S_END};
    case (step)
      5'd0:  c = '{op: OP_MINUS, grp: GRP_UNIT,  target: S_END};
      5'd1:  c = '{op: OP_ZERO,  grp: GRP_UNIT,  target: S_END};
      5'd2:  c = '{op: OP_BIG,   grp: GRP_UNIT,  target: S_END};
      5'd3:  c = '{op: OP_JDONE, grp: GRP_UNIT,  target: S_END};
      5'd4:  c = '{op: OP_CONV,  grp: GRP_UNIT,  target: S_END};
      // millions group
      5'd5:  c = '{op: OP_JZ,    grp: GRP_MILL,  target: 5'd13};
      5'd6:  c = '{op: OP_HDIG,  grp: GRP_MILL,  target: S_END};
      5'd7:  c = '{op: OP_HUND,  grp: GRP_MILL,  target: S_END};
      5'd8:  c = '{op: OP_ANDH,  grp: GRP_MILL,  target: S_END};
      5'd9:  c = '{op: OP_TENS,  grp: GRP_MILL,  target: S_END};
      5'd10: c = '{op: OP_UNIT,  grp: GRP_MILL,  target: S_END};
      5'd11: c = '{op: OP_SUFX,  grp: GRP_MILL,  target: S_END};
      5'd12: c = '{op: OP_ANDS,  grp: GRP_MILL,  target: S_END};
      // thousands group
      5'd13: c = '{op: OP_JZ,    grp: GRP_THOUS, target: 5'd21};
      5'd14: c = '{op: OP_HDIG,  grp: GRP_THOUS, target: S_END};
      5'd15: c = '{op: OP_HUND,  grp: GRP_THOUS, target: S_END};
      5'd16: c = '{op: OP_ANDH,  grp: GRP_THOUS, target: S_END};
      5'd17: c = '{op: OP_TENS,  grp: GRP_THOUS, target: S_END};
      5'd18: c = '{op: OP_UNIT,  grp: GRP_THOUS, target: S_END};
      5'd19: c = '{op: OP_SUFX,  grp: GRP_THOUS, target: S_END};
      5'd20: c = '{op: OP_ANDS,  grp: GRP_THOUS, target: S_END};
      // units group
      5'd21: c = '{op: OP_JZ,    grp: GRP_UNIT,  target: S_END};
      5'd22: c = '{op: OP_HDIG,  grp: GRP_UNIT,  target: S_END};
      5'd23: c = '{op: OP_HUND,  grp: GRP_UNIT,  target: S_END};
      5'd24: c = '{op: OP_ANDH,  grp: GRP_UNIT,  target: S_END};
      5'd25: c = '{op: OP_TENS,  grp: GRP_UNIT,  target: S_END};
      5'd26: c = '{op: OP_UNIT,  grp: GRP_UNIT,  target: S_END};
      default: c = '{op: OP_END, grp: GRP_UNIT,  target: S_END};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nwt_bin2bcd.sv =====
`default_nettype none

// Shift-and-add-3 binary to decimal converter, one bit per cycle while shift_i is high
module nwt_bin2bcd (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      load_i,
  input  wire logic [nwt_pkg::MAG_W-1:0] mag_i,
  input  wire logic                      shift_i,
  output logic                           done_o,
  output logic [nwt_pkg::BCD_W-1:0]      bcd_o
);
  import nwt_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [BCD_W-1:0] adj;

  // Add 3 to every digit of 5 or more, then shift in the next bit
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3 : bcd_q[4*k +: 4];
    end
    cnt_d = cnt_q;
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (load_i) begin
      cnt_d = '0;
      bin_d = mag_i;
      bcd_d = '0;
    end else if (shift_i) begin
      cnt_d = cnt_q + CNT_W'(1);
      bin_d = {bin_q[MAG_W-2:0], 1'b0};
      bcd_d = {adj[BCD_W-2:0], bin_q[MAG_W-1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = (cnt_q == CNT_W'(MAG_W));
  assign bcd_o  = bcd_q;

endmodule

`default_nettype wire

// ===== rtl/core/norwegian_number_to_word_tokens.sv =====
`default_nettype none

// Norwegian number speaker, token form.
// Pulse start with number_i and neuter_i while busy is low; the transaction
// is taken at that edge and busy rises. The block then strobes each token of the
// transaction on word_o / too_big_o / last_o, one cycle each, in speaking order,
// and last_o marks the final token. busy falls at the edge that shows the last
// token, and a new number may be started from then on.
// A small microprogram (28 steps, one per cycle but held while the conversion
// runs) drives the datapath. Zero, the most negative value and out-of-range
// magnitudes skip the conversion and jump to the end step. Other numbers first
// run a shift-and-add-3 conversion to nine decimal digits, then walk the three
// digit groups, jumping over whole groups that are zero. Each token is held until
// the step that finds the next token (or the end) and leaves in the cycle after
// that step, so the final one can be flagged.
// The receiver cannot stall: every strobed token must be taken in its cycle.
// Reset clears busy, the step counter and the strobe; no token is pending.
module norwegian_number_to_word_tokens (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] number_i,
  input  wire logic        neuter_i,
  output logic             strobe,
  output logic [6:0]       word_o,
  output logic             too_big_o,
  output logic             last_o
);
  import nwt_pkg::*;

  // Control state
  logic              busy_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic              pend_v_q;
  logic              strobe_q;

  // Per-transaction flags and pending token
  logic              neg_q, zero_q, big_q, done_q, neut_q;
  logic [WORD_W-1:0] pend_word_q, word_q;
  logic              pend_big_q, big_out_q, last_q;

  // Input decode
  logic              accept;
  logic [31:0]       mag32;
  logic              min_neg;

  // Converter
  logic              conv_shift, conv_done;
  logic [BCD_W-1:0]  bcd;

  // Step decode
  ctrl_t             ctrl;
  logic [3:0]        h, t, u;
  logic              neut_g, rem_nz, rest_small;
  logic [WORD_W-1:0] tens, tu;
  logic              emit, emit_big, fin;
  logic [WORD_W-1:0] emit_word;

  assign accept  = start && !busy_q;
  assign min_neg = (number_i == 32'h8000_0000);
  assign mag32   = number_i[31] ? (32'd0 - number_i) : number_i;

  nwt_bin2bcd u_b2d (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .mag_i  (mag32[MAG_W-1:0]),
    .shift_i(conv_shift),
    .done_o (conv_done),
    .bcd_o  (bcd)
  );

  // Digits of the selected group
  always_comb begin
    unique case (ctrl.grp)
      GRP_MILL: begin
        h = bcd[35:32]; t = bcd[31:28]; u = bcd[27:24];
        neut_g     = 1'b0;
        rest_small = (bcd[23:8] == '0) && (bcd[7:0] != '0);
      end
      GRP_THOUS: begin
        h = bcd[23:20]; t = bcd[19:16]; u = bcd[15:12];
        neut_g     = 1'b1;
        rest_small = (bcd[11:8] == '0) && (bcd[7:0] != '0);
      end
      default: begin
        h = bcd[11:8]; t = bcd[7:4]; u = bcd[3:0];
        neut_g     = neut_q;
        rest_small = 1'b0;
      end
    endcase
  end

  assign rem_nz = (t != 4'd0) || (u != 4'd0);
  assign tens   = ({3'b000, t} << 3) + ({3'b000, t} << 1);
  assign tu     = tens + {3'b000, u};

  // Microcode decode: what the current step emits and where it goes next
  always_comb begin
    ctrl       = nwt_ucode(step_q);
    emit       = 1'b0;
    emit_big   = 1'b0;
    emit_word  = W_ZERO;
    fin        = 1'b0;
    conv_shift = 1'b0;
    step_d     = step_q + STEP_W'(1);
    unique case (ctrl.op)
      OP_MINUS: begin
        emit      = neg_q;
        emit_word = W_MINUS;
      end
      OP_ZERO: begin
        emit      = zero_q;
        emit_word = W_ZERO;
      end
      OP_BIG: begin
        emit      = big_q;
        emit_big  = 1'b1;
        emit_word = W_ZERO;
      end
      OP_JDONE: begin
        if (done_q) begin
          step_d = ctrl.target;
        end
      end
      OP_CONV: begin
        if (!conv_done) begin
          conv_shift = 1'b1;
          step_d     = step_q;
        end
      end
      OP_JZ: begin
        if ((h == 4'd0) && !rem_nz) begin
          step_d = ctrl.target;
        end
      end
      OP_HDIG: begin
        emit      = (h != 4'd0);
        emit_word = (h == 4'd1) ? W_ONE_N : {3'b000, h};
      end
      OP_HUND: begin
        emit      = (h != 4'd0);
        emit_word = W_HUND;
      end
      OP_ANDH: begin
        emit      = (h != 4'd0) && rem_nz;
        emit_word = W_AND;
      end
      OP_TENS: begin
        emit = rem_nz;
        if (t < 4'd2) begin
          emit_word = ((tu == 7'd1) && neut_g) ? W_ONE_N : tu;
        end else begin
          emit_word = tens;
        end
      end
      OP_UNIT: begin
        emit      = (t >= 4'd2) && (u != 4'd0);
        emit_word = ((u == 4'd1) && neut_g) ? W_ONE_N : {3'b000, u};
      end
      OP_SUFX: begin
        emit      = 1'b1;
        emit_word = (ctrl.grp == GRP_MILL) ? W_MILL : W_THOUS;
      end
      OP_ANDS: begin
        emit      = rest_small;
        emit_word = W_AND;
      end
      OP_END: begin
        fin = 1'b1;
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  // Sequencer control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      step_q   <= '0;
      pend_v_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= busy_q && pend_v_q && (emit || fin);
      if (accept) begin
        busy_q   <= 1'b1;
        step_q   <= '0;
        pend_v_q <= 1'b0;
      end else if (busy_q) begin
        step_q <= step_d;
        if (fin) begin
          busy_q   <= 1'b0;
          pend_v_q <= 1'b0;
        end else if (emit) begin
          pend_v_q <= 1'b1;
        end
      end
    end
  end

  // Transaction flags, pending token and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q  <= number_i[31];
      zero_q <= (number_i == 32'd0);
      big_q  <= !min_neg && (mag32 >= BILLION);
      done_q <= (number_i == 32'd0) || min_neg || (mag32 >= BILLION);
      neut_q <= neuter_i;
    end
    if (busy_q && emit) begin
      pend_word_q <= emit_word;
      pend_big_q  <= emit_big;
    end
    word_q    <= pend_word_q;
    big_out_q <= pend_big_q;
    last_q    <= fin;
  end

  assign busy      = busy_q;
  assign strobe    = strobe_q;
  assign word_o    = word_q;
  assign too_big_o = big_out_q;
  assign last_o    = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/nwt_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the token stream
module nwt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        strobe,
  input wire logic [6:0]  word_o,
  input wire logic        too_big_o,
  input wire logic        last_o
);

  // An accepted transaction keeps the block busy in the next cycle
  `NWT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // Busy ends exactly with the final token of the run
  `NWT_ASSERT_IMPLY(a_fell_last, $fell(busy), strobe && last_o)

  // No final token while the block is still busy
  `NWT_ASSERT_IMPLY(a_last_idle, strobe && last_o, !busy)

  // The error token closes the run and carries word zero
  `NWT_ASSERT_IMPLY(a_big_last, strobe && too_big_o, last_o && (word_o == 7'd0))

endmodule

bind norwegian_number_to_word_tokens nwt_checker u_nwt_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .strobe   (strobe),
  .word_o   (word_o),
  .too_big_o(too_big_o),
  .last_o   (last_o)
);

`default_nettype wire
